FILE: rtl/gbc_pkg.sv
package gbc_pkg;

    localparam int unsigned ROT_AMT     = 11;
    localparam int unsigned LAST_ROUND  = 31;
    localparam int unsigned FWD_ROUNDS  = 24;
    localparam int unsigned NIBBLE_W    = 4;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;
    localparam int unsigned SBOX_ROWS   = 8;
    localparam int unsigned KEY_WORDS   = 8;
    localparam int unsigned BLOCK_BYTES = 8;

    localparam logic [1:0] OP_BLOCK      = 2'd0;
    localparam logic [1:0] OP_LOAD_ROW   = 2'd1;
    localparam logic [1:0] OP_LOAD_CHAIN = 2'd2;

    localparam logic [2:0] MODE_SIMPLE_ENC = 3'd0;
    localparam logic [2:0] MODE_SIMPLE_DEC = 3'd1;
    localparam logic [2:0] MODE_GAMMA      = 3'd2;
    localparam logic [2:0] MODE_CFB_ENC    = 3'd3;
    localparam logic [2:0] MODE_CFB_DEC    = 3'd4;
    localparam logic [2:0] MODE_MAC        = 3'd5;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_KEY_01 = 3'd1;
    localparam logic [2:0] CFG_KEY_23 = 3'd2;
    localparam logic [2:0] CFG_KEY_45 = 3'd3;
    localparam logic [2:0] CFG_KEY_67 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic last_rnd;
    } t_round_ctl;

    function automatic logic [BLOCK_BYTES-1:0] byte_mask(input logic [3:0] bc);
        logic [3:0]             n;
        logic [BLOCK_BYTES-1:0] m;
        begin
            n = ((bc == 4'd0) || (bc > 4'(BLOCK_BYTES))) ? 4'(BLOCK_BYTES) : bc;
            for (int j = 0; j < BLOCK_BYTES; j++) begin
                m[j] = (4'(j) < n);
            end
            return m;
        end
    endfunction

    function automatic logic [63:0] expand_mask(input logic [BLOCK_BYTES-1:0] m);
        logic [63:0] r;
        begin
            for (int j = 0; j < BLOCK_BYTES; j++) begin
                r[8*j +: 8] = {8{m[j]}};
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/gbc_chain_mem.sv
module gbc_chain_mem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [63:0] i_wdata,
    input  logic        i_re,
    output logic [63:0] o_rdata
);

    logic [63:0] r_chain;
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (i_we) begin
            r_chain <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_chain;
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gbc_sbox_mem.sv
module gbc_sbox_mem (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [2:0]  i_row,
    input  logic [63:0] i_wdata,
    input  logic [31:0] i_x,
    output logic [31:0] o_sub
);

    logic [63:0] r_rows [gbc_pkg::SBOX_ROWS];
    logic [3:0]  idx    [gbc_pkg::SBOX_ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_rows[i_row] <= i_wdata;
        end
    end

    always_comb begin
        for (int i = 0; i < gbc_pkg::SBOX_ROWS; i++) begin
            idx[i] = i_x[gbc_pkg::NIBBLE_W*i +: gbc_pkg::NIBBLE_W] & gbc_pkg::NIBBLE_MASK;
            o_sub[gbc_pkg::NIBBLE_W*i +: gbc_pkg::NIBBLE_W] =
                r_rows[i][gbc_pkg::NIBBLE_W*idx[i] +: gbc_pkg::NIBBLE_W];
        end
    end

endmodule

FILE: rtl/gbc_round.sv
module gbc_round (
    input  logic                i_clk,
    input  gbc_pkg::t_round_ctl i_ctl,
    input  logic [63:0]         i_init,
    input  logic [31:0]         i_key,
    input  logic [31:0]         i_sub,
    output logic [31:0]         o_sum,
    output logic [63:0]         o_block
);

    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] f;

    assign o_sum = r_b + i_key;
    assign f     = (i_sub << gbc_pkg::ROT_AMT) | (i_sub >> (32 - gbc_pkg::ROT_AMT));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_init[31:0];
            r_b <= i_init[63:32];
        end else if (i_ctl.step) begin
            if (i_ctl.last_rnd) begin
                r_a <= r_a ^ f;
            end else begin
                r_a <= r_b;
                r_b <= r_a ^ f;
            end
        end
    end

    assign o_block = {r_b, r_a};

endmodule

FILE: rtl/gost_block_cipher_modes_core.sv
// Data block: chain read, 32 rounds and a finish step, then the result is registered.
// No new item is accepted while a data block is in progress; all rounds use one round unit.
// Row and start-value loads give no result.
// A finished result waits in the output register; the next item is accepted meanwhile.
// Reset (synchronous, active low) clears control, mode, keys and chain value.
// Substitution rows are not cleared and must be loaded before use.
module gost_block_cipher_modes_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_data_block,
    input  logic [3:0]  i_byte_count,
    input  logic [2:0]  i_sbox_row,
    input  logic        i_last_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_result_block,
    output logic        o_is_mac
);

    gbc_pkg::t_state     r_state, n_state;
    gbc_pkg::t_round_ctl rnd_ctl;

    logic [2:0]  r_mode;
    logic [31:0] r_key [gbc_pkg::KEY_WORDS];
    logic [63:0] r_data;
    logic [7:0]  r_bmask;
    logic        r_last;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_block;
    logic        r_out_mac;

    logic        accept;
    logic [63:0] mask;
    logic [63:0] chain_rd;
    logic        chain_we;
    logic [63:0] chain_wdata;
    logic        chain_re;
    logic        row_we;
    logic [63:0] init_blk;
    logic [63:0] cblk;
    logic [31:0] sum;
    logic [31:0] sub;
    logic [4:0]  e;
    logic [2:0]  kidx;
    logic        dec;
    logic        fin_commit;
    logic        has_out;
    logic        upd_chain;
    logic [63:0] res;
    logic [63:0] chain_next;
    logic        res_mac;

    assign o_in_ready = (r_state == gbc_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign mask       = gbc_pkg::expand_mask(r_bmask);
    assign dec        = (r_mode == gbc_pkg::MODE_SIMPLE_DEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= gbc_pkg::MODE_SIMPLE_ENC;
            for (int i = 0; i < gbc_pkg::KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gbc_pkg::CFG_MODE: r_mode <= i_cfg_wdata[2:0];
                gbc_pkg::CFG_KEY_01: begin
                    r_key[0] <= i_cfg_wdata[31:0];
                    r_key[1] <= i_cfg_wdata[63:32];
                end
                gbc_pkg::CFG_KEY_23: begin
                    r_key[2] <= i_cfg_wdata[31:0];
                    r_key[3] <= i_cfg_wdata[63:32];
                end
                gbc_pkg::CFG_KEY_45: begin
                    r_key[4] <= i_cfg_wdata[31:0];
                    r_key[5] <= i_cfg_wdata[63:32];
                end
                gbc_pkg::CFG_KEY_67: begin
                    r_key[6] <= i_cfg_wdata[31:0];
                    r_key[7] <= i_cfg_wdata[63:32];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data  <= i_data_block;
            r_bmask <= gbc_pkg::byte_mask(i_byte_count);
            r_last  <= i_last_block;
        end
    end

    assign row_we   = accept && (i_operation == gbc_pkg::OP_LOAD_ROW);
    assign chain_re = accept && (i_operation == gbc_pkg::OP_BLOCK);

    gbc_chain_mem u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (chain_we),
        .i_wdata (chain_wdata),
        .i_re    (chain_re),
        .o_rdata (chain_rd)
    );

    gbc_sbox_mem u_sbox (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_row   (i_sbox_row),
        .i_wdata (i_data_block),
        .i_x     (sum),
        .o_sub   (sub)
    );

    assign e    = dec ? (5'(gbc_pkg::LAST_ROUND) - r_cnt) : r_cnt;
    assign kidx = (e < 5'(gbc_pkg::FWD_ROUNDS)) ? e[2:0] : ~e[2:0];

    always_comb begin
        unique case (r_mode) inside
            gbc_pkg::MODE_SIMPLE_ENC, gbc_pkg::MODE_SIMPLE_DEC: init_blk = r_data;
            gbc_pkg::MODE_MAC: init_blk = chain_rd ^ (r_data & mask);
            default:           init_blk = chain_rd;
        endcase
    end

    gbc_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (rnd_ctl),
        .i_init  (init_blk),
        .i_key   (r_key[kidx]),
        .i_sub   (sub),
        .o_sum   (sum),
        .o_block (cblk)
    );

    always_comb begin
        res        = (r_data ^ cblk) & mask;
        chain_next = cblk;
        has_out    = 1'b1;
        upd_chain  = 1'b0;
        res_mac    = 1'b0;
        unique case (r_mode) inside
            gbc_pkg::MODE_SIMPLE_ENC, gbc_pkg::MODE_SIMPLE_DEC: begin
                res = cblk;
            end
            gbc_pkg::MODE_GAMMA: begin
                upd_chain  = 1'b1;
                chain_next = chain_rd + 64'd1;
            end
            gbc_pkg::MODE_CFB_ENC: begin
                upd_chain  = 1'b1;
                chain_next = res;
            end
            gbc_pkg::MODE_CFB_DEC: begin
                upd_chain  = 1'b1;
                chain_next = r_data & mask;
            end
            gbc_pkg::MODE_MAC: begin
                upd_chain  = 1'b1;
                has_out    = r_last;
                res_mac    = 1'b1;
                res        = {32'd0, cblk[31:0]};
                chain_next = r_last ? 64'd0 : cblk;
            end
            default: begin
                has_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        rnd_ctl     = '0;
        fin_commit  = 1'b0;
        chain_we    = 1'b0;
        chain_wdata = i_data_block;
        unique case (r_state)
            gbc_pkg::ST_IDLE: begin
                if (accept && (i_operation == gbc_pkg::OP_BLOCK)) begin
                    n_state = gbc_pkg::ST_READ;
                end
                chain_we = accept && (i_operation == gbc_pkg::OP_LOAD_CHAIN);
            end
            gbc_pkg::ST_READ: begin
                rnd_ctl.load = 1'b1;
                n_cnt        = '0;
                n_state      = gbc_pkg::ST_RUN;
            end
            gbc_pkg::ST_RUN: begin
                rnd_ctl.step     = 1'b1;
                rnd_ctl.last_rnd = (r_cnt == 5'(gbc_pkg::LAST_ROUND));
                n_cnt            = r_cnt + 5'd1;
                if (rnd_ctl.last_rnd) begin
                    n_state = gbc_pkg::ST_FINISH;
                end
            end
            gbc_pkg::ST_FINISH: begin
                fin_commit  = !has_out || !r_out_valid || i_out_ready;
                chain_we    = fin_commit && upd_chain;
                chain_wdata = chain_next;
                if (fin_commit) begin
                    n_state = gbc_pkg::ST_IDLE;
                end
            end
            default: n_state = gbc_pkg::ST_IDLE;
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || (fin_commit && has_out);

    always_ff @(posedge i_clk) begin
        if (fin_commit && has_out) begin
            r_out_block <= res;
            r_out_mac   <= res_mac;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_block = r_out_block;
    assign o_is_mac       = r_out_mac;

endmodule

FILE: rtl/gbc_checker.sv
module gbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_index,
    input logic [63:0] i_cfg_wdata,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_operation,
    input logic [63:0] i_data_block,
    input logic [3:0]  i_byte_count,
    input logic [2:0]  i_sbox_row,
    input logic        i_last_block,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_result_block,
    input logic        o_is_mac
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_block) && $stable(o_is_mac))
        else $error("result changed or dropped while stalled");

    a_mac_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_mac |-> o_result_block[63:32] == 32'd0)
        else $error("mac result has nonzero upper half");

    a_busy_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == gbc_pkg::OP_BLOCK) |=> !o_in_ready)
        else $error("ready right after a data block transaction");

    a_rounds_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == gbc_pkg::OP_BLOCK) |-> ##33 !o_in_ready)
        else $error("data block finished before all rounds");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear control state");

endmodule

bind gost_block_cipher_modes_core gbc_checker u_gbc_checker (.*);

FILE: tb/sv/gost_modes_checker.sv
module gost_modes_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_data_block,
    input  logic [3:0]  i_byte_count,
    input  logic [2:0]  i_sbox_row,
    input  logic        i_last_block,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_result_block,
    input  logic        i_is_mac,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic [63:0] block;
        logic        mac;
    } t_gost_result;

    logic [63:0]  sbox_rows [gbc_pkg::SBOX_ROWS];
    logic [31:0]  key_words [gbc_pkg::KEY_WORDS];
    logic [63:0]  chain_block;
    logic [2:0]   cipher_mode;
    t_gost_result expected_results [$];

    function automatic logic [31:0] substitute(input logic [31:0] x);
        logic [31:0] y;
        logic [3:0]  idx;
        for (int i = 0; i < gbc_pkg::SBOX_ROWS; i++) begin
            idx = x[4*i +: 4];
            y[4*i +: 4] = sbox_rows[i][4*idx +: 4];
        end
        return y;
    endfunction

    function automatic logic [31:0] feistel_f(input logic [31:0] half, input logic [31:0] k);
        logic [31:0] s;
        s = substitute(half + k);
        return {s[20:0], s[31:21]};
    endfunction

    function automatic logic [31:0] round_key(input int rnd, input logic dec);
        int e;
        e = dec ? int'(gbc_pkg::LAST_ROUND) - rnd : rnd;
        if (e < int'(gbc_pkg::FWD_ROUNDS)) begin
            return key_words[3'(e)];
        end
        return key_words[3'(int'(gbc_pkg::LAST_ROUND) - e)];
    endfunction

    function automatic logic [63:0] gost_cipher(input logic [63:0] blk, input logic dec);
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] t;
        n1 = blk[31:0];
        n2 = blk[63:32];
        for (int r = 0; r < int'(gbc_pkg::LAST_ROUND); r++) begin
            t  = n1 ^ feistel_f(n2, round_key(r, dec));
            n1 = n2;
            n2 = t;
        end
        n1 = n1 ^ feistel_f(n2, round_key(gbc_pkg::LAST_ROUND, dec));
        return {n2, n1};
    endfunction

    function automatic logic [63:0] byte_keep(input logic [3:0] bc);
        logic [63:0] keep;
        int          n;
        n = (bc == 4'd0 || bc > 4'd8) ? 8 : int'(bc);
        keep = '0;
        for (int j = 0; j < n; j++) begin
            keep[8*j +: 8] = 8'hFF;
        end
        return keep;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] exp_val,
                                 input logic [63:0] got_val);
        if (o_mismatches < 10) begin
            $display("mismatch (%0s): expected %h, got %h", what, exp_val, got_val);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_gost_result prediction;
        t_gost_result oldest;
        logic [63:0]  keep;
        logic [63:0]  stream;
        if (!i_rst_n) begin
            chain_block = '0;
            cipher_mode = gbc_pkg::MODE_SIMPLE_ENC;
            for (int i = 0; i < gbc_pkg::KEY_WORDS; i++) begin
                key_words[i] = '0;
            end
            expected_results.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gbc_pkg::CFG_MODE: cipher_mode = i_cfg_wdata[2:0];
                    gbc_pkg::CFG_KEY_01: {key_words[1], key_words[0]} = i_cfg_wdata;
                    gbc_pkg::CFG_KEY_23: {key_words[3], key_words[2]} = i_cfg_wdata;
                    gbc_pkg::CFG_KEY_45: {key_words[5], key_words[4]} = i_cfg_wdata;
                    gbc_pkg::CFG_KEY_67: {key_words[7], key_words[6]} = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected transaction", '0, i_result_block);
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_result_block !== oldest.block) begin
                        note_mismatch("result_block", oldest.block, i_result_block);
                    end
                    if (i_is_mac !== oldest.mac) begin
                        note_mismatch("is_mac", 64'(oldest.mac), 64'(i_is_mac));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_operation)
                    gbc_pkg::OP_LOAD_ROW: sbox_rows[i_sbox_row] = i_data_block;
                    gbc_pkg::OP_LOAD_CHAIN: chain_block = i_data_block;
                    gbc_pkg::OP_BLOCK: begin
                        keep = byte_keep(i_byte_count);
                        prediction.mac = 1'b0;
                        case (cipher_mode) inside
                            gbc_pkg::MODE_SIMPLE_ENC, gbc_pkg::MODE_SIMPLE_DEC: begin
                                prediction.block = gost_cipher(i_data_block,
                                    cipher_mode == gbc_pkg::MODE_SIMPLE_DEC);
                                expected_results.push_back(prediction);
                            end
                            gbc_pkg::MODE_GAMMA: begin
                                stream = gost_cipher(chain_block, 1'b0);
                                prediction.block = (i_data_block ^ stream) & keep;
                                expected_results.push_back(prediction);
                                chain_block = chain_block + 64'd1;
                            end
                            gbc_pkg::MODE_CFB_ENC, gbc_pkg::MODE_CFB_DEC: begin
                                stream = gost_cipher(chain_block, 1'b0);
                                prediction.block = (i_data_block ^ stream) & keep;
                                expected_results.push_back(prediction);
                                chain_block = (cipher_mode == gbc_pkg::MODE_CFB_ENC) ?
                                              prediction.block : (i_data_block & keep);
                            end
                            gbc_pkg::MODE_MAC: begin
                                chain_block = gost_cipher(chain_block ^ (i_data_block & keep),
                                                          1'b0);
                                if (i_last_block) begin
                                    prediction.block = {32'd0, chain_block[31:0]};
                                    prediction.mac   = 1'b1;
                                    expected_results.push_back(prediction);
                                    chain_block = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

FILE: tb/sv/gost_block_cipher_modes_core_tb.sv
module gost_block_cipher_modes_core_tb;

    localparam logic [1:0] OP_NONE         = 2'd3;
    localparam logic [2:0] MODE_UNUSED     = 3'd7;
    localparam int         SETTLE_CYCLES   = 40;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         RANDOM_PHASES   = 12;
    localparam int         PHASE_ITEMS     = 38;
    localparam int         IDLE_PERCENT    = 26;

    typedef enum logic [1:0] {
        KEYS_RANDOM,
        KEYS_ZERO,
        KEYS_ONES
    } t_key_fill;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_operation;
    logic [63:0] i_data_block;
    logic [3:0]  i_byte_count;
    logic [2:0]  i_sbox_row;
    logic        i_last_block;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_result_block;
    logic        o_is_mac;

    int   mismatch_count;
    int   results_outstanding;
    int   cycle_count    = 0;
    int   rx_hold_reqs   = 0;
    int   rx_hold_served = 0;
    int   rx_hold_left   = 0;
    logic steady         = 1'b0;

    logic [2:0] phase_modes [6] = '{gbc_pkg::MODE_SIMPLE_ENC, gbc_pkg::MODE_SIMPLE_DEC,
                                    gbc_pkg::MODE_GAMMA, gbc_pkg::MODE_CFB_ENC,
                                    gbc_pkg::MODE_CFB_DEC, gbc_pkg::MODE_MAC};

    always #5 i_clk = ~i_clk;

    gost_block_cipher_modes_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_data_block   (i_data_block),
        .i_byte_count   (i_byte_count),
        .i_sbox_row     (i_sbox_row),
        .i_last_block   (i_last_block),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_block (o_result_block),
        .o_is_mac       (o_is_mac)
    );

    gost_modes_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_data_block   (i_data_block),
        .i_byte_count   (i_byte_count),
        .i_sbox_row     (i_sbox_row),
        .i_last_block   (i_last_block),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_block (o_result_block),
        .i_is_mac       (o_is_mac),
        .o_mismatches   (mismatch_count),
        .o_outstanding  (results_outstanding)
    );

    task automatic send_item(input logic [1:0] op, input logic [63:0] data,
                             input logic [3:0] bc, input logic [2:0] row, input logic last);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_operation  = op;
        i_data_block = data;
        i_byte_count = bc;
        i_sbox_row   = row;
        i_last_block = last;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain(input int settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (results_outstanding != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic configure(input logic [2:0] mode, input t_key_fill fill);
        logic [63:0] key_pair;
        drain(SETTLE_CYCLES);
        write_reg(gbc_pkg::CFG_MODE, {61'd0, mode});
        for (int i = 0; i < 4; i++) begin
            case (fill)
                KEYS_ZERO: key_pair = '0;
                KEYS_ONES: key_pair = '1;
                default: key_pair = {$urandom, $urandom};
            endcase
            write_reg(3'(gbc_pkg::CFG_KEY_01 + i), key_pair);
        end
    endtask

    // receiver: random stalls, steady stretch, and long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_ready = 1'b0;
                rx_hold_left--;
            end else if (rx_hold_reqs != rx_hold_served) begin
                rx_hold_served++;
                rx_hold_left = HOLD_OFF_CYCLES;
                i_out_ready  = 1'b0;
            end else if (steady) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[gost_block_cipher_modes_core] ERROR");
        $finish;
    end

    initial begin
        int         pick;
        logic [1:0] op;
        logic [3:0] bc;
        t_key_fill  fill;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = gbc_pkg::CFG_MODE;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_operation  = gbc_pkg::OP_BLOCK;
        i_data_block = '0;
        i_byte_count = 4'd8;
        i_sbox_row   = '0;
        i_last_block = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // load every substitution row before any block
        configure(gbc_pkg::MODE_SIMPLE_ENC, KEYS_RANDOM);
        for (int r = 0; r < gbc_pkg::SBOX_ROWS; r++) begin
            send_item(gbc_pkg::OP_LOAD_ROW, {$urandom, $urandom}, 4'd8, 3'(r), 1'b0);
        end
        send_item(gbc_pkg::OP_BLOCK, '0, 4'd8, 3'd0, 1'b0);
        send_item(gbc_pkg::OP_BLOCK, '1, 4'd8, 3'd7, 1'b1);
        send_item(OP_NONE, {$urandom, $urandom}, 4'd8, 3'd0, 1'b0);

        configure(gbc_pkg::MODE_SIMPLE_DEC, KEYS_ONES);
        send_item(gbc_pkg::OP_BLOCK, '1, 4'd15, 3'd0, 1'b0);

        configure(gbc_pkg::MODE_GAMMA, KEYS_ZERO);
        send_item(gbc_pkg::OP_LOAD_CHAIN, '1, 4'd8, 3'd0, 1'b0);
        send_item(gbc_pkg::OP_BLOCK, {$urandom, $urandom}, 4'd8, 3'd0, 1'b0);
        send_item(gbc_pkg::OP_BLOCK, {$urandom, $urandom}, 4'd1, 3'd0, 1'b1);

        configure(gbc_pkg::MODE_CFB_ENC, KEYS_RANDOM);
        send_item(gbc_pkg::OP_LOAD_CHAIN, '0, 4'd8, 3'd0, 1'b0);
        send_item(gbc_pkg::OP_BLOCK, {$urandom, $urandom}, 4'd0, 3'd0, 1'b0);
        send_item(gbc_pkg::OP_BLOCK, {$urandom, $urandom}, 4'd15, 3'd0, 1'b0);

        configure(gbc_pkg::MODE_CFB_DEC, KEYS_RANDOM);
        send_item(gbc_pkg::OP_BLOCK, {$urandom, $urandom}, 4'd3, 3'd0, 1'b0);

        configure(gbc_pkg::MODE_MAC, KEYS_RANDOM);
        send_item(gbc_pkg::OP_LOAD_CHAIN, '0, 4'd8, 3'd0, 1'b0);
        send_item(gbc_pkg::OP_BLOCK, {$urandom, $urandom}, 4'd8, 3'd0, 1'b0);
        send_item(gbc_pkg::OP_BLOCK, {$urandom, $urandom}, 4'd5, 3'd0, 1'b1);

        configure(MODE_UNUSED, KEYS_RANDOM);
        send_item(gbc_pkg::OP_BLOCK, {$urandom, $urandom}, 4'd8, 3'd0, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            fill = (ph == 3) ? KEYS_ZERO : (ph == 8) ? KEYS_ONES : KEYS_RANDOM;
            configure(phase_modes[ph % 6], fill);
            steady = (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 5) begin
                    rx_hold_reqs++;
                end
                if (ph == 7 && n == 20) begin
                    drain(0);
                end
                pick = $urandom_range(99);
                if (pick < 4) begin
                    op = gbc_pkg::OP_LOAD_ROW;
                end else if (pick < 10) begin
                    op = gbc_pkg::OP_LOAD_CHAIN;
                end else if (pick < 12) begin
                    op = OP_NONE;
                end else begin
                    op = gbc_pkg::OP_BLOCK;
                end
                bc = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
                send_item(op, {$urandom, $urandom}, bc, 3'($urandom_range(7)),
                          $urandom_range(3) == 0);
            end
            steady = 1'b0;
        end

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("[gost_block_cipher_modes_core] OK");
        end else begin
            $display("[gost_block_cipher_modes_core] ERROR");
        end
        $finish;
    end

endmodule
